@@ sv/dbtu_pkg.sv @@
`default_nettype none

package dbtu_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdBits       = 16;
  localparam int unsigned SlotBits     = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned AddrBits     = 32;
  localparam int unsigned OutIdBits    = 16;

  typedef logic [IdBits-1:0]       id_t;
  typedef logic [AddrBits-1:0]     addr_t;
  typedef logic [SlotBits-1:0]     age_t;
  typedef logic [TableEntries-1:0] entry_vec_t;
  typedef logic [OutIdBits-1:0]    out_id_t;

  typedef enum logic [2:0] {
    ModeTick     = 3'd0,
    ModeAdd      = 3'd1,
    ModeRemove   = 3'd2,
    ModeLookup   = 3'd3,
    ModeUser     = 3'd4,
    ModeStepIn   = 3'd5,
    ModeStepOver = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    TrigNone     = 3'd0,
    TrigBreak    = 3'd1,
    TrigStepIn   = 3'd2,
    TrigStepOver = 3'd3,
    TrigUser     = 3'd4
  } trigger_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusNotFound = 2'd1,
    StatusFull     = 2'd2
  } status_e;

  localparam logic [6:0] OpcJal    = 7'h6f;
  localparam logic [6:0] OpcJalr   = 7'h67;
  localparam logic [2:0] Funct3Jr  = 3'd0;
  localparam logic [4:0] RegRa     = 5'd1;
  localparam addr_t      RetOffset = addr_t'(4);

  typedef struct packed {
    logic  add;
    logic  remove;
    logic  by_id;
    addr_t address;
    id_t   id;
  } tbl_req_t;

  typedef struct packed {
    logic  found;
    id_t   hit_id;
    addr_t hit_address;
    logic  full;
    id_t   next_id;
  } tbl_rsp_t;

  function automatic out_id_t id_to_out(id_t id);
    logic [31:0] w;
    w = 32'(id);
    return w[OutIdBits-1:0];
  endfunction

  function automatic id_t id_from_in(out_id_t id);
    logic [31:0] w;
    w = 32'(id);
    return w[IdBits-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/dbtu_table.sv @@
`default_nettype none

module dbtu_table
  import dbtu_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire tbl_req_t req_i,
  output tbl_rsp_t      rsp_o
);

  entry_vec_t valid_q;
  id_t        id_q   [TableEntries];
  addr_t      addr_q [TableEntries];
  age_t       age_q  [TableEntries];
  id_t        next_id_q;

  entry_vec_t match;
  entry_vec_t newest;
  entry_vec_t free_oh;
  age_t       sel_age;
  logic       full;
  logic       do_add;
  logic       do_remove;

  // newest matching entry has the lowest age; ages of valid entries are unique
  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      match[i] = valid_q[i] &&
                 (req_i.by_id ? (id_q[i] == req_i.id) : (addr_q[i] == req_i.address));
    end
    for (int i = 0; i < TableEntries; i++) begin
      newest[i] = match[i];
      for (int j = 0; j < TableEntries; j++) begin
        if (match[j] && (age_q[j] < age_q[i])) begin
          newest[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    rsp_o             = '0;
    sel_age           = '0;
    rsp_o.found       = |match;
    for (int i = 0; i < TableEntries; i++) begin
      if (newest[i]) begin
        rsp_o.hit_id      = rsp_o.hit_id | id_q[i];
        rsp_o.hit_address = rsp_o.hit_address | addr_q[i];
        sel_age           = sel_age | age_q[i];
      end
    end
    rsp_o.full    = full;
    rsp_o.next_id = next_id_q;
  end

  // lowest free slot
  assign free_oh   = ~valid_q & (valid_q + entry_vec_t'(1));
  assign full      = &valid_q;
  assign do_add    = req_i.add && !full;
  assign do_remove = req_i.remove && (|match);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      next_id_q <= '0;
    end else begin
      if (do_add) begin
        valid_q   <= valid_q | free_oh;
        next_id_q <= next_id_q + id_t'(1);
      end else if (do_remove) begin
        valid_q <= valid_q & ~newest;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TableEntries; i++) begin
      if (do_add) begin
        if (free_oh[i]) begin
          id_q[i]   <= next_id_q;
          addr_q[i] <= req_i.address;
          age_q[i]  <= '0;
        end else if (valid_q[i]) begin
          age_q[i] <= age_q[i] + age_t'(1);
        end
      end else if (do_remove) begin
        if (valid_q[i] && (age_q[i] > sel_age)) begin
          age_q[i] <= age_q[i] - age_t'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/debug_breakpoint_trigger_unit_core.sv @@
// channel   | handshake                      | payload
// ----------+--------------------------------+----------------------------------------------
// item in   | start, busy (always low)       | mode_i, address_i, bp_id_i, instruction_i
// result    | done_o, one cycle, no stall    | trigger_o, hit_id_o, read_address_o,
//           |                                | status_o, assigned_id_o
// config    | cfg_valid_i, cfg_ready_o       | cfg_data_i (debug_enable)
//
// an item is taken every cycle; it passes through the item register, then the result register, before done_o
// the item is registered, then the breakpoint compare and priority select run on it combinationally
// table and flags update at the end of the compare, so the next item sees them
// reset clears the table valid bits, id counter, flags and enable; no clearing pass
// results cannot be held off by the receiver, nothing inside ever stalls
`default_nettype none

module debug_breakpoint_trigger_unit_core
  import dbtu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  mode_i,
  input  wire logic [31:0] address_i,
  input  wire logic [15:0] bp_id_i,
  input  wire logic [31:0] instruction_i,
  output logic             done_o,
  output logic [2:0]       trigger_o,
  output logic [15:0]      hit_id_o,
  output logic [31:0]      read_address_o,
  output logic [1:0]       status_o,
  output logic [15:0]      assigned_id_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i
);

  logic        item_q;
  logic [2:0]  mode_q;
  addr_t       address_q;
  out_id_t     bp_id_q;
  logic [31:0] instr_q;

  logic  enable_q;
  logic  user_q, user_d;
  logic  step_in_q, step_in_d;
  logic  step_over_q, step_over_d;
  addr_t ret_addr_q, ret_addr_d;

  logic        done_q;
  trigger_e    trig_q, trig_d;
  out_id_t     hit_q, hit_d;
  addr_t       rd_addr_q, rd_addr_d;
  status_e     status_q, status_d;
  out_id_t     assigned_q, assigned_d;

  tbl_req_t tbl_req;
  tbl_rsp_t tbl_rsp;
  logic     is_call;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  dbtu_table u_table (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (tbl_req),
    .rsp_o (tbl_rsp)
  );

  assign is_call = ((instr_q[6:0] == OpcJal) ||
                    ((instr_q[6:0] == OpcJalr) && (instr_q[14:12] == Funct3Jr))) &&
                   (instr_q[11:7] == RegRa);

  always_comb begin
    tbl_req.add     = item_q && (mode_q == ModeAdd);
    tbl_req.remove  = item_q && (mode_q == ModeRemove);
    tbl_req.by_id   = (mode_q != ModeTick);
    tbl_req.address = address_q;
    tbl_req.id      = id_from_in(bp_id_q);
  end

  always_comb begin
    user_d      = user_q;
    step_in_d   = step_in_q;
    step_over_d = step_over_q;
    ret_addr_d  = ret_addr_q;
    trig_d      = TrigNone;
    hit_d       = '0;
    rd_addr_d   = '0;
    status_d    = StatusOk;
    assigned_d  = '0;
    unique case (mode_e'(mode_q))
      ModeTick: begin
        if (enable_q) begin
          priority if (user_q) begin
            trig_d = TrigUser;
          end else if (step_in_q) begin
            trig_d = TrigStepIn;
          end else if (step_over_q && (ret_addr_q == address_q)) begin
            trig_d = TrigStepOver;
          end else if (tbl_rsp.found) begin
            trig_d = TrigBreak;
            hit_d  = id_to_out(tbl_rsp.hit_id);
          end else begin
            trig_d = TrigNone;
          end
          if (trig_d != TrigNone) begin
            user_d      = 1'b0;
            step_in_d   = 1'b0;
            step_over_d = 1'b0;
          end
        end
      end
      ModeAdd: begin
        if (tbl_rsp.full) begin
          status_d = StatusFull;
        end else begin
          assigned_d = id_to_out(tbl_rsp.next_id);
        end
      end
      ModeRemove: begin
        if (!tbl_rsp.found) begin
          status_d = StatusNotFound;
        end
      end
      ModeLookup: begin
        if (tbl_rsp.found) begin
          rd_addr_d = tbl_rsp.hit_address;
        end else begin
          status_d = StatusNotFound;
        end
      end
      ModeUser: begin
        user_d = 1'b1;
      end
      ModeStepIn: begin
        step_in_d = 1'b1;
      end
      ModeStepOver: begin
        if (is_call) begin
          step_over_d = 1'b1;
          ret_addr_d  = address_q + RetOffset;
        end else begin
          step_in_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q      <= 1'b0;
      done_q      <= 1'b0;
      enable_q    <= 1'b0;
      user_q      <= 1'b0;
      step_in_q   <= 1'b0;
      step_over_q <= 1'b0;
      ret_addr_q  <= '0;
    end else begin
      item_q <= start && !busy;
      done_q <= item_q;
      if (cfg_valid_i && cfg_ready_o) begin
        enable_q <= cfg_data_i;
      end
      if (item_q) begin
        user_q      <= user_d;
        step_in_q   <= step_in_d;
        step_over_q <= step_over_d;
        ret_addr_q  <= ret_addr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      mode_q    <= mode_i;
      address_q <= address_i;
      bp_id_q   <= bp_id_i;
      instr_q   <= instruction_i;
    end
    if (item_q) begin
      trig_q     <= trig_d;
      hit_q      <= hit_d;
      rd_addr_q  <= rd_addr_d;
      status_q   <= status_d;
      assigned_q <= assigned_d;
    end
  end

  assign done_o         = done_q;
  assign trigger_o      = trig_q;
  assign hit_id_o       = hit_q;
  assign read_address_o = rd_addr_q;
  assign status_o       = status_q;
  assign assigned_id_o  = assigned_q;

endmodule

`default_nettype wire

@@ sv/dbtu_checker.sv @@
`default_nettype none

module dbtu_checker
  import dbtu_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic [2:0]  trigger_o,
  input wire logic [15:0] hit_id_o,
  input wire logic [31:0] read_address_o,
  input wire logic [1:0]  status_o,
  input wire logic [15:0] assigned_id_o
);

  a_done_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without an item");

  a_item_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("item without a result");

  a_hit_only_on_break: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (trigger_o != TrigBreak)) |-> (hit_id_o == '0))
    else $error("hit id outside a breakpoint trigger");

  a_trigger_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (trigger_o != TrigNone)) |->
      ((status_o == StatusOk) && (read_address_o == '0) && (assigned_id_o == '0)))
    else $error("trigger mixed with command result");

endmodule

bind debug_breakpoint_trigger_unit_core dbtu_checker u_dbtu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .trigger_o     (trigger_o),
  .hit_id_o      (hit_id_o),
  .read_address_o(read_address_o),
  .status_o      (status_o),
  .assigned_id_o (assigned_id_o)
);

`default_nettype wire
